>>> rtl/mpf_pkg.sv
// Shared types, constants and arithmetic helpers of the Morse pair force pipeline.
package mpf_pkg;

   // Fixed scale of the van der Waals and switch factors (Q1.20).
   localparam int SCALE_BITS = 20;
   // log2(e) in Q29.
   localparam logic [29:0] LOG2E_Q29 = 30'd774541002;
   // Exponent argument clamp, in whole units.
   localparam int EXP_LIMIT = 32;
   // Largest supported log2 of the exp table depth.
   localparam int MAX_TAB_LOG = 12;
   // Register stages of one Morse evaluation.
   localparam int MORSE_LAT = 13;
   // Quotient bits produced by the force divider.
   localparam int DIV_BITS = 33;

   localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

   // Variant codes; anything above the repulsive code is unknown.
   localparam logic [1:0] VAR_MORSE     = 2'd0;
   localparam logic [1:0] VAR_REPULSIVE = 2'd1;

   // Shift mode register bits.
   localparam int SHIFT_POT_BIT   = 0;
   localparam int SHIFT_FORCE_BIT = 1;

   // Configuration register indexes.
   localparam logic CSR_CUTOFF     = 1'b0;
   localparam logic CSR_SHIFT_MODE = 1'b1;

   // Per-pair fields that ride alongside the Morse evaluation.
   typedef struct packed {
      logic [30:0]       r;
      logic [2:0][31:0]  sep;
      logic [20:0]       vdw;
      logic [20:0]       sw;
      logic              sel;
      logic [1:0]        variant;
   } side_type;

   // Fields that ride alongside the divider.
   typedef struct packed {
      logic [30:0]        r;
      logic signed [31:0] pair;
      logic signed [31:0] swe;
      logic               sel;
   } dsd_type;

   // State of one divider lane.
   typedef struct packed {
      logic [62:0]         rem;
      logic [DIV_BITS-1:0] quo;
      logic                neg;
      logic                nz;
      logic                big;
   } lane_type;

   // Saturate a signed value to the 32-bit range.
   function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
      logic signed [31:0] res;
      if (v > 72'(SAT_MAX)) res = SAT_MAX;
      else if (v < 72'(SAT_MIN)) res = SAT_MIN;
      else res = v[31:0];
      return res;
   endfunction

   // Integer square root, used only while building the exp table.
   function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
      logic [63:0] x;
      logic [63:0] r;
      logic [63:0] bit_w;
      x = x_in;
      r = 64'd0;
      bit_w = 64'd1 << 62;
      for (int n = 0; n < 32; n++) begin
         if (x >= r + bit_w) begin
            x = x - (r + bit_w);
            r = (r >> 1) + bit_w;
         end else begin
            r = r >> 1;
         end
         bit_w = bit_w >> 2;
      end
      return r;
   endfunction

   // Table entry idx of 2^(idx/2^lg) in Q30, built from repeated square roots of two.
   function automatic logic [31:0] exp_entry(input int idx, input int lg);
      logic [63:0] roots [MAX_TAB_LOG+1];
      logic [63:0] acc;
      roots[0] = 64'd2 << 30;
      for (int j = 1; j <= MAX_TAB_LOG; j++) begin
         roots[j] = (j <= lg) ? isqrt64(roots[j-1] << 30) : 64'd0;
      end
      acc = 64'd1 << 30;
      for (int b = 0; b < MAX_TAB_LOG; b++) begin
         if (b < lg && idx[b]) acc = (acc * roots[lg-b] + (64'd1 << 29)) >> 30;
      end
      return acc[31:0];
   endfunction

endpackage

>>> rtl/mpf_morse.sv
// Pipelined Morse potential and derivative for one distance, exp by table.
module mpf_morse
   import mpf_pkg::*;
#(
   parameter int FRAC_BITS       = 20,
   parameter int EXP_TABLE_DEPTH = 256
) (
   input  logic               clock,
   input  logic               en,
   input  logic [30:0]        distance,
   input  logic [30:0]        well_depth,
   input  logic [30:0]        eq_distance,
   input  logic [30:0]        beta,
   input  logic [1:0]         variant,
   output logic signed [31:0] pot,
   output logic signed [31:0] deriv
);

   localparam int TAB_LOG = $clog2(EXP_TABLE_DEPTH);
   localparam int LOW     = FRAC_BITS - TAB_LOG;
   localparam int T_W     = FRAC_BITS + 7;
   localparam int UM_W    = T_W + 30;
   localparam int U_W     = UM_W - 29;
   localparam int PI_W    = 32 + FRAC_BITS;
   localparam logic signed [63:0] LIM = 64'(EXP_LIMIT) <<< FRAC_BITS;
   localparam logic [FRAC_BITS-1:0] REM_MASK = FRAC_BITS'((64'd1 << LOW) - 64'd1);
   localparam logic [30:0] MAX31 = 31'h7FFF_FFFF;

   // Constant table of 2^(i/depth), one extra entry of 2.0 at the top.
   logic [31:0] exp_rom [EXP_TABLE_DEPTH+1];
   for (genvar g = 0; g <= EXP_TABLE_DEPTH; g++) begin : g_rom
      assign exp_rom[g] = (g == EXP_TABLE_DEPTH) ? 32'h8000_0000 : exp_entry(g, TAB_LOG);
   end

   // Stage registers.
   logic signed [31:0]     s1_dr_ff;
   logic [30:0]            s1_beta_ff, s1_de_ff;
   logic [1:0]             s1_var_ff;
   logic signed [63:0]     s2_prod_ff;
   logic [61:0]            s2_dbp_ff;
   logic [30:0]            s2_de_ff;
   logic [1:0]             s2_var_ff;
   logic signed [UM_W-1:0] s3_umul_ff;
   logic                   s3_hi_ff, s3_lo_ff;
   logic [30:0]            s3_db_ff, s3_de_ff;
   logic [1:0]             s3_var_ff;
   logic [31:0]            s4_lo_ff, s4_diff_ff;
   logic [FRAC_BITS-1:0]   s4_rem_ff;
   logic signed [8:0]      s4_sh_ff;
   logic                   s4_hi_ff, s4_lo_flag_ff;
   logic [30:0]            s4_db_ff, s4_de_ff;
   logic [1:0]             s4_var_ff;
   logic [PI_W-1:0]        s5_pi_ff;
   logic [31:0]            s5_lo_ff;
   logic signed [8:0]      s5_sh_ff;
   logic                   s5_hi_ff, s5_lo_flag_ff;
   logic [30:0]            s5_db_ff, s5_de_ff;
   logic [1:0]             s5_var_ff;
   logic [31:0]            s6_m_ff;
   logic signed [8:0]      s6_sh_ff;
   logic                   s6_hi_ff, s6_lo_flag_ff;
   logic [30:0]            s6_db_ff, s6_de_ff;
   logic [1:0]             s6_var_ff;
   logic [30:0]            s7_e_ff, s7_db_ff, s7_de_ff;
   logic [1:0]             s7_var_ff;
   logic [61:0]            s8_eep_ff;
   logic [30:0]            s8_e_ff, s8_db_ff, s8_de_ff;
   logic [1:0]             s8_var_ff;
   logic [30:0]            s9_e2_ff, s9_e_ff, s9_db_ff, s9_de_ff;
   logic [1:0]             s9_var_ff;
   logic signed [31:0]     s10_opa_ff, s10_opb_ff;
   logic [30:0]            s10_db_ff, s10_de_ff;
   logic [1:0]             s10_var_ff;
   logic signed [63:0]     s11_pp_ff, s11_dp_ff;
   logic [1:0]             s11_var_ff;
   logic signed [31:0]     s12_pot_ff, s12_dm_ff;
   logic [1:0]             s12_var_ff;
   logic signed [31:0]     s13_pot_ff, s13_der_ff;

   // Next values.
   logic signed [63:0]     s3_t;
   logic signed [T_W-1:0]  s3_tc;
   logic signed [UM_W-1:0] s3_umul_in;
   logic [61:0]            s3_dbs;
   logic [30:0]            s3_db_in;
   logic signed [U_W-1:0]  s4_u;
   logic signed [7:0]      s4_k;
   logic [FRAC_BITS-1:0]   s4_f;
   logic [TAB_LOG:0]       s4_idx;
   logic [31:0]            s4_lo_in, s4_hi_val, s4_diff_in;
   logic signed [8:0]      s4_sh_in;
   logic [30:0]            s7_e_in;
   logic [63:0]            s7_wide;
   logic [8:0]             s7_ns;
   logic [61:0]            s9_sh;
   logic [30:0]            s9_e2_in;
   logic signed [33:0]     s10_a, s10_b;
   logic signed [31:0]     s10_opa_in, s10_opb_in;

   // Exponent argument, clamp flags and base-2 conversion.
   always_comb begin
      s3_t       = s2_prod_ff >>> FRAC_BITS;
      s3_tc      = s3_t[T_W-1:0];
      s3_umul_in = UM_W'(s3_tc) * UM_W'($signed({1'b0, LOG2E_Q29}));
      s3_dbs     = s2_dbp_ff >> FRAC_BITS;
      s3_db_in   = (s3_dbs > 62'(MAX31)) ? MAX31 : s3_dbs[30:0];
   end

   // Split into integer and fraction, then read the two table neighbors.
   always_comb begin
      s4_u       = s3_umul_ff[UM_W-1:29];
      s4_k       = s4_u[U_W-1:FRAC_BITS];
      s4_f       = s4_u[FRAC_BITS-1:0];
      s4_idx     = (TAB_LOG+1)'(s4_f[FRAC_BITS-1:LOW]);
      s4_lo_in   = exp_rom[s4_idx];
      s4_hi_val  = exp_rom[s4_idx + 1'b1];
      s4_diff_in = (s4_hi_val > s4_lo_in) ? (s4_hi_val - s4_lo_in) : 32'd0;
      s4_sh_in   = 9'(s4_k) + 9'(FRAC_BITS - 30);
   end

   // Scale the mantissa by the power of two and saturate.
   always_comb begin
      s7_wide = 64'd0;
      s7_ns   = 9'(-s6_sh_ff);
      s7_e_in = 31'd0;
      if (s6_hi_ff) begin
         s7_e_in = MAX31;
      end else if (s6_lo_flag_ff) begin
         s7_e_in = 31'd0;
      end else if (!s6_sh_ff[8]) begin
         if (s6_sh_ff >= 9'sd32) begin
            s7_e_in = MAX31;
         end else begin
            s7_wide = 64'(s6_m_ff) << s6_sh_ff[4:0];
            s7_e_in = (s7_wide > 64'(MAX31)) ? MAX31 : s7_wide[30:0];
         end
      end else if (s7_ns < 9'd63) begin
         s7_wide = 64'(s6_m_ff) >> s7_ns[5:0];
         s7_e_in = (s7_wide > 64'(MAX31)) ? MAX31 : s7_wide[30:0];
      end
   end

   // Square of the exponential, saturated.
   always_comb begin
      s9_sh    = s8_eep_ff >> FRAC_BITS;
      s9_e2_in = (s9_sh > 62'(MAX31)) ? MAX31 : s9_sh[30:0];
   end

   // Operands of the energy and derivative products, by variant.
   always_comb begin
      s10_a = $signed(34'(s9_e2_ff)) - $signed(34'({s9_e_ff, 1'b0}));
      s10_b = $signed(34'(s9_e_ff)) - $signed(34'(s9_e2_ff));
      if (s9_var_ff == VAR_MORSE) begin
         s10_opa_in = sat32(72'(s10_a));
         s10_opb_in = sat32(72'(s10_b));
      end else begin
         s10_opa_in = $signed({1'b0, s9_e2_ff});
         s10_opb_in = $signed({1'b0, s9_e2_ff});
      end
   end

   // Pipeline registers, all moving together.
   always_ff @(posedge clock) begin
      if (en) begin
         s1_dr_ff      <= $signed({1'b0, eq_distance}) - $signed({1'b0, distance});
         s1_beta_ff    <= beta;
         s1_de_ff      <= well_depth;
         s1_var_ff     <= variant;
         s2_prod_ff    <= 64'(s1_dr_ff) * 64'($signed({1'b0, s1_beta_ff}));
         s2_dbp_ff     <= 62'(s1_de_ff) * 62'(s1_beta_ff);
         s2_de_ff      <= s1_de_ff;
         s2_var_ff     <= s1_var_ff;
         s3_umul_ff    <= s3_umul_in;
         s3_hi_ff      <= s3_t > LIM;
         s3_lo_ff      <= s3_t < -LIM;
         s3_db_ff      <= s3_db_in;
         s3_de_ff      <= s2_de_ff;
         s3_var_ff     <= s2_var_ff;
         s4_lo_ff      <= s4_lo_in;
         s4_diff_ff    <= s4_diff_in;
         s4_rem_ff     <= s4_f & REM_MASK;
         s4_sh_ff      <= s4_sh_in;
         s4_hi_ff      <= s3_hi_ff;
         s4_lo_flag_ff <= s3_lo_ff;
         s4_db_ff      <= s3_db_ff;
         s4_de_ff      <= s3_de_ff;
         s4_var_ff     <= s3_var_ff;
         s5_pi_ff      <= PI_W'(s4_diff_ff) * PI_W'(s4_rem_ff);
         s5_lo_ff      <= s4_lo_ff;
         s5_sh_ff      <= s4_sh_ff;
         s5_hi_ff      <= s4_hi_ff;
         s5_lo_flag_ff <= s4_lo_flag_ff;
         s5_db_ff      <= s4_db_ff;
         s5_de_ff      <= s4_de_ff;
         s5_var_ff     <= s4_var_ff;
         s6_m_ff       <= s5_lo_ff + 32'(s5_pi_ff >> LOW);
         s6_sh_ff      <= s5_sh_ff;
         s6_hi_ff      <= s5_hi_ff;
         s6_lo_flag_ff <= s5_lo_flag_ff;
         s6_db_ff      <= s5_db_ff;
         s6_de_ff      <= s5_de_ff;
         s6_var_ff     <= s5_var_ff;
         s7_e_ff       <= s7_e_in;
         s7_db_ff      <= s6_db_ff;
         s7_de_ff      <= s6_de_ff;
         s7_var_ff     <= s6_var_ff;
         s8_eep_ff     <= 62'(s7_e_ff) * 62'(s7_e_ff);
         s8_e_ff       <= s7_e_ff;
         s8_db_ff      <= s7_db_ff;
         s8_de_ff      <= s7_de_ff;
         s8_var_ff     <= s7_var_ff;
         s9_e2_ff      <= s9_e2_in;
         s9_e_ff       <= s8_e_ff;
         s9_db_ff      <= s8_db_ff;
         s9_de_ff      <= s8_de_ff;
         s9_var_ff     <= s8_var_ff;
         s10_opa_ff    <= s10_opa_in;
         s10_opb_ff    <= s10_opb_in;
         s10_db_ff     <= s9_db_ff;
         s10_de_ff     <= s9_de_ff;
         s10_var_ff    <= s9_var_ff;
         s11_pp_ff     <= 64'($signed({1'b0, s10_de_ff})) * 64'(s10_opa_ff);
         s11_dp_ff     <= 64'($signed({1'b0, s10_db_ff})) * 64'(s10_opb_ff);
         s11_var_ff    <= s10_var_ff;
         s12_pot_ff    <= sat32(72'(s11_pp_ff >>> FRAC_BITS));
         s12_dm_ff     <= sat32(72'(s11_dp_ff >>> FRAC_BITS));
         s12_var_ff    <= s11_var_ff;
         s13_pot_ff    <= s12_pot_ff;
         s13_der_ff    <= (s12_var_ff == VAR_MORSE) ?
                          sat32(72'(s12_dm_ff) + 72'(s12_dm_ff)) :
                          sat32(-(72'(s12_dm_ff) + 72'(s12_dm_ff)));
      end
   end

   assign pot   = s13_pot_ff;
   assign deriv = s13_der_ff;

endmodule

>>> rtl/morse_pair_force.sv
// Top level of the Morse pair force and energy pipeline.
//
//  channel | direction | handshake            | contents
//  req     | in        | req_valid/req_ready  | one atom pair and its Morse parameters
//  rsp     | out       | rsp_valid/rsp_ready  | energy increments and force components
//  csr     | in        | csr_write_en         | cutoff radius and shift mode
//
// One word enters per cycle while the output is not stalled; a word passes 53
// register stages on its way to rsp_valid:
// 13 stages of Morse evaluation, 5 of cutoff correction and scaling, 1 of sign handling,
// 33 of the bit-per-stage force divider and 1 output register.
// Reset is synchronous and clears the valid bits and the configuration registers.
// A stalled output freezes every stage at once, so no word is dropped or repeated.
module morse_pair_force
   import mpf_pkg::*;
#(
   parameter int FRAC_BITS       = 20,
   parameter int EXP_TABLE_DEPTH = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [30:0]        req_distance,
   input  logic signed [31:0] req_sep_x,
   input  logic signed [31:0] req_sep_y,
   input  logic signed [31:0] req_sep_z,
   input  logic [20:0]        req_vdw_scale,
   input  logic [20:0]        req_switch_value,
   input  logic               req_is_selected,
   input  logic [30:0]        req_well_depth,
   input  logic [30:0]        req_eq_distance,
   input  logic [30:0]        req_beta,
   input  logic [1:0]         req_variant,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_pair_energy,
   output logic signed [31:0] rsp_switched_energy,
   output logic signed [31:0] rsp_selected_energy,
   output logic signed [31:0] rsp_force_x,
   output logic signed [31:0] rsp_force_y,
   output logic signed [31:0] rsp_force_z,
   input  logic               csr_write_en,
   input  logic               csr_index,
   input  logic [30:0]        csr_wdata
);

   localparam int C1_STG = MORSE_LAT;
   localparam int D0_STG = MORSE_LAT + 5;
   localparam int NSTG   = D0_STG + DIV_BITS + 2;

   logic               advance;
   logic [NSTG-1:0]    vld_ff;
   logic [30:0]        cutoff_ff;
   logic [1:0]         shift_mode_ff;
   logic signed [31:0] pot_r, der_r, pot_c, der_c;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cutoff_ff     <= '0;
         shift_mode_ff <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_CUTOFF:     cutoff_ff     <= csr_wdata;
            CSR_SHIFT_MODE: shift_mode_ff <= csr_wdata[1:0];
            default:        ;
         endcase
      end
   end

   // The whole pipeline moves whenever the output register can take a word.
   assign advance   = !vld_ff[NSTG-1] || rsp_ready;
   assign req_ready = advance;
   assign rsp_valid = vld_ff[NSTG-1];

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (advance) vld_ff <= {vld_ff[NSTG-2:0], req_valid};
   end

   // Morse terms at the pair distance and at the cutoff radius.
   mpf_morse #(.FRAC_BITS(FRAC_BITS), .EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)) u_morse_r (
      .clock       (clock),
      .en          (advance),
      .distance    (req_distance),
      .well_depth  (req_well_depth),
      .eq_distance (req_eq_distance),
      .beta        (req_beta),
      .variant     (req_variant),
      .pot         (pot_r),
      .deriv       (der_r)
   );

   mpf_morse #(.FRAC_BITS(FRAC_BITS), .EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)) u_morse_c (
      .clock       (clock),
      .en          (advance),
      .distance    (cutoff_ff),
      .well_depth  (req_well_depth),
      .eq_distance (req_eq_distance),
      .beta        (req_beta),
      .variant     (req_variant),
      .pot         (pot_c),
      .deriv       (der_c)
   );

   // Pair fields delayed to line up with the Morse results.
   side_type side_in;
   side_type side_ff [MORSE_LAT];

   always_comb begin
      side_in.r       = req_distance;
      side_in.sep[0]  = req_sep_x;
      side_in.sep[1]  = req_sep_y;
      side_in.sep[2]  = req_sep_z;
      side_in.vdw     = req_vdw_scale;
      side_in.sw      = req_switch_value;
      side_in.sel     = req_is_selected;
      side_in.variant = req_variant;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         side_ff[0] <= side_in;
         for (int i = 1; i < MORSE_LAT; i++) side_ff[i] <= side_ff[i-1];
      end
   end

   // Stage one: variant and shift mode select the cutoff terms.
   side_type           c1_side_ff, c2_side_ff, c3_side_ff, c4_side_ff, c5_side_ff;
   logic signed [31:0] c1_pot_ff, c1_der_ff, c1_potc_ff, c1_derc_ff;
   logic signed [63:0] c1_prodc_ff;
   logic               c1_frc_ff;
   logic signed [31:0] c1_pot_in, c1_der_in, c1_potc_in, c1_derc_in;
   logic signed [31:0] c1_rdiff;
   logic               c1_unk, c1_pmode, c1_fmode;

   always_comb begin
      c1_unk     = side_ff[MORSE_LAT-1].variant > VAR_REPULSIVE;
      c1_pmode   = shift_mode_ff[SHIFT_POT_BIT];
      c1_fmode   = !c1_pmode && shift_mode_ff[SHIFT_FORCE_BIT];
      c1_pot_in  = c1_unk ? '0 : pot_r;
      c1_der_in  = c1_unk ? '0 : der_r;
      c1_potc_in = (c1_unk || !(c1_pmode || c1_fmode)) ? '0 : pot_c;
      c1_derc_in = (c1_unk || !c1_fmode) ? '0 : der_c;
      c1_rdiff   = $signed({1'b0, side_ff[MORSE_LAT-1].r}) - $signed({1'b0, cutoff_ff});
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         c1_side_ff  <= side_ff[MORSE_LAT-1];
         c1_pot_ff   <= c1_pot_in;
         c1_der_ff   <= c1_der_in;
         c1_potc_ff  <= c1_potc_in;
         c1_derc_ff  <= c1_derc_in;
         c1_prodc_ff <= 64'(der_c) * 64'(c1_rdiff);
         c1_frc_ff   <= !c1_unk && c1_fmode;
      end
   end

   // Stage two: shifted force adds the linear correction to the cutoff energy.
   logic signed [31:0] c2_pot_ff, c2_der_ff, c2_potc_ff, c2_derc_ff;
   logic signed [31:0] c2_corr, c2_potc_in;

   always_comb begin
      c2_corr    = sat32(72'(c1_prodc_ff >>> FRAC_BITS));
      c2_potc_in = c1_frc_ff ? sat32(72'(c1_potc_ff) + 72'(c2_corr)) : c1_potc_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         c2_side_ff <= c1_side_ff;
         c2_pot_ff  <= c1_pot_ff;
         c2_der_ff  <= c1_der_ff;
         c2_potc_ff <= c2_potc_in;
         c2_derc_ff <= c1_derc_ff;
      end
   end

   // Stage three: corrected differences and the combined scale factor.
   logic signed [31:0] c3_ediff_ff, c3_ddiff_ff;
   logic [21:0]        c3_sv_ff;
   logic [41:0]        c3_svp;

   assign c3_svp = 42'(c2_side_ff.sw) * 42'(c2_side_ff.vdw);

   always_ff @(posedge clock) begin
      if (advance) begin
         c3_side_ff  <= c2_side_ff;
         c3_ediff_ff <= sat32(72'(c2_pot_ff) - 72'(c2_potc_ff));
         c3_ddiff_ff <= sat32(72'(c2_der_ff) - 72'(c2_derc_ff));
         c3_sv_ff    <= 22'(c3_svp >> SCALE_BITS);
      end
   end

   // Stage four: scaled pair energy and scaled derivative.
   logic signed [31:0] c4_pair_ff, c4_dudr_ff;
   logic signed [63:0] c4_pp, c4_dp;

   always_comb begin
      c4_pp = 64'($signed({1'b0, c3_side_ff.vdw})) * 64'(c3_ediff_ff);
      c4_dp = 64'($signed({1'b0, c3_sv_ff})) * 64'(c3_ddiff_ff);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         c4_side_ff <= c3_side_ff;
         c4_pair_ff <= sat32(72'(c4_pp >>> SCALE_BITS));
         c4_dudr_ff <= sat32(72'(c4_dp >>> SCALE_BITS));
      end
   end

   // Stage five: switched energy and the force numerators.
   logic signed [31:0]      c5_pair_ff, c5_swe_ff;
   logic signed [2:0][63:0] c5_num_ff;
   logic signed [63:0]      c5_sp;

   assign c5_sp = 64'($signed({1'b0, c4_side_ff.sw})) * 64'(c4_pair_ff);

   always_ff @(posedge clock) begin
      if (advance) begin
         c5_side_ff <= c4_side_ff;
         c5_pair_ff <= c4_pair_ff;
         c5_swe_ff  <= sat32(72'(c5_sp >>> SCALE_BITS));
         for (int i = 0; i < 3; i++) begin
            c5_num_ff[i] <= 64'($signed(c4_side_ff.sep[i])) * 64'(c4_dudr_ff);
         end
      end
   end

   // Divider: energies ride along, each lane divides one numerator by the distance.
   dsd_type            dsd_in;
   dsd_type            dsd_ff [DIV_BITS+1];
   lane_type           div_ff [3][DIV_BITS+1];
   logic signed [31:0] frc_in [3];

   always_comb begin
      dsd_in.r    = c5_side_ff.r;
      dsd_in.pair = c5_pair_ff;
      dsd_in.swe  = c5_swe_ff;
      dsd_in.sel  = c5_side_ff.sel;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dsd_ff[0] <= dsd_in;
         for (int j = 1; j <= DIV_BITS; j++) dsd_ff[j] <= dsd_ff[j-1];
      end
   end

   for (genvar ln = 0; ln < 3; ln++) begin : g_lane
      lane_type    d0_in;
      logic [63:0] d0_mag;
      lane_type    fin;

      // Magnitude, sign and an early check for quotients beyond the divider range.
      always_comb begin
         d0_mag      = c5_num_ff[ln][63] ? 64'(-c5_num_ff[ln]) : 64'(c5_num_ff[ln]);
         d0_in.rem   = d0_mag[62:0];
         d0_in.quo   = '0;
         d0_in.neg   = c5_num_ff[ln][63];
         d0_in.nz    = c5_num_ff[ln] != 64'sd0;
         d0_in.big   = d0_mag >= (64'(c5_side_ff.r) << DIV_BITS);
      end

      always_ff @(posedge clock) begin
         if (advance) div_ff[ln][0] <= d0_in;
      end

      // One restoring step per stage, most significant quotient bit first.
      for (genvar j = 0; j < DIV_BITS; j++) begin : g_step
         lane_type    step_in;
         logic [63:0] dsh;
         always_comb begin
            step_in = div_ff[ln][j];
            dsh     = 64'(dsd_ff[j].r) << (DIV_BITS - 1 - j);
            if (64'(div_ff[ln][j].rem) >= dsh) begin
               step_in.rem = 63'(64'(div_ff[ln][j].rem) - dsh);
               step_in.quo[DIV_BITS-1-j] = 1'b1;
            end
         end
         always_ff @(posedge clock) begin
            if (advance) div_ff[ln][j+1] <= step_in;
         end
      end

      // Apply the sign and saturate; a zero distance gives 0 or a signed full-scale force.
      always_comb begin
         fin = div_ff[ln][DIV_BITS];
         if (dsd_ff[DIV_BITS].r == 31'd0) begin
            frc_in[ln] = fin.nz ? (fin.neg ? SAT_MIN : SAT_MAX) : 32'sd0;
         end else if (fin.big) begin
            frc_in[ln] = fin.neg ? SAT_MIN : SAT_MAX;
         end else if (fin.neg) begin
            frc_in[ln] = (fin.quo > 33'h0_8000_0000) ? SAT_MIN :
                         $signed(32'(33'd0 - fin.quo));
         end else begin
            frc_in[ln] = (fin.quo > 33'h0_7FFF_FFFF) ? SAT_MAX : $signed(fin.quo[31:0]);
         end
      end
   end

   // Output register.
   logic signed [31:0] rsp_pair_ff, rsp_swe_ff, rsp_sele_ff;
   logic signed [31:0] rsp_fx_ff, rsp_fy_ff, rsp_fz_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_pair_ff <= dsd_ff[DIV_BITS].pair;
         rsp_swe_ff  <= dsd_ff[DIV_BITS].swe;
         rsp_sele_ff <= dsd_ff[DIV_BITS].sel ? dsd_ff[DIV_BITS].swe : 32'sd0;
         rsp_fx_ff   <= frc_in[0];
         rsp_fy_ff   <= frc_in[1];
         rsp_fz_ff   <= frc_in[2];
      end
   end

   assign rsp_pair_energy     = rsp_pair_ff;
   assign rsp_switched_energy = rsp_swe_ff;
   assign rsp_selected_energy = rsp_sele_ff;
   assign rsp_force_x         = rsp_fx_ff;
   assign rsp_force_y         = rsp_fy_ff;
   assign rsp_force_z         = rsp_fz_ff;

`ifndef SYNTHESIS
   // A held output word must stop the input side in the same cycle.
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("input accepted while output word is stalled");

   // An accepted word occupies the first stage on the next cycle.
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> vld_ff[0])
      else $error("accepted word missing from first stage");

   // An unknown variant clears every energy and derivative term.
   a_unknown_zero: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[C1_STG] && c1_side_ff.variant > VAR_REPULSIVE) |->
      (c1_pot_ff == 32'sd0 && c1_der_ff == 32'sd0 &&
       c1_potc_ff == 32'sd0 && c1_derc_ff == 32'sd0))
      else $error("unknown variant left nonzero terms");
`endif

endmodule

>>> tb/sv/morse_pair_force_tb.sv
// Self-checking testbench of the Morse pair force pipeline with a fixed-point scoreboard.
module morse_pair_force_tb;
   import mpf_pkg::*;

   // Variant codes beyond the two the block evaluates.
   localparam logic [1:0] VAR_UNKNOWN = 2'd2;
   localparam logic [1:0] VAR_SPARE   = 2'd3;
   // Shift mode settings.
   localparam logic [1:0] SHIFT_NONE  = 2'd0;
   localparam logic [1:0] SHIFT_POT   = 2'd1;
   localparam logic [1:0] SHIFT_FORCE = 2'd2;
   localparam logic [1:0] SHIFT_BOTH  = 2'd3;
   localparam longint ONE = 64'sd1 << 20;

   typedef struct {
      logic [30:0]        r;
      logic signed [31:0] sx, sy, sz;
      logic [20:0]        vdw, sw;
      logic               sel;
      logic [30:0]        de, re, beta;
      logic [1:0]         variant;
   } pair_word_type;

   typedef struct {
      logic signed [31:0] pair, swe, sele, fx, fy, fz;
   } force_word_type;

   // Predicts the energy and force words and checks them in order.
   class force_ledger;
      longint unsigned exp_tab[0:256];
      int              tab_log;
      longint          rcut;
      logic [1:0]      mode;
      force_word_type  expected[$];
      int              fails;

      function new();
         longint unsigned roots[0:12];
         longint unsigned acc;
         tab_log = 8;
         rcut = 0;
         mode = SHIFT_NONE;
         fails = 0;
         roots[0] = 64'd2 << 30;
         for (int j = 1; j <= tab_log; j++) roots[j] = root(roots[j-1] << 30);
         for (int i = 0; i < 256; i++) begin
            acc = 64'd1 << 30;
            for (int b = 0; b < tab_log; b++)
               if ((i >> b) & 1) acc = (acc * roots[tab_log-b] + (64'd1 << 29)) >> 30;
            exp_tab[i] = acc;
         end
         exp_tab[256] = 64'd2 << 30;
      endfunction

      // Bitwise integer square root.
      function longint unsigned root(longint unsigned x_in);
         longint unsigned x, res, b;
         x = x_in;
         res = 0;
         b = 64'd1 << 62;
         while (b > x) b >>= 2;
         while (b != 0) begin
            if (x >= res + b) begin
               x -= res + b;
               res = (res >> 1) + b;
            end else res >>= 1;
            b >>= 2;
         end
         return res;
      endfunction

      function longint clamp32(longint v);
         if (v > 64'sh7FFFFFFF) return 64'sh7FFFFFFF;
         if (v < -64'sh80000000) return -64'sh80000000;
         return v;
      endfunction

      function longint fmul(longint a, longint b);
         return clamp32((a * b) >>> 20);
      endfunction

      // exp(t) by base-2 range reduction and table interpolation.
      function longint fexp(longint t);
         longint lim, u, k, sh;
         longint unsigned f, idx, rem, lo, hi, m;
         lim = 64'sd32 << 20;
         if (t > lim) return 64'sh7FFFFFFF;
         if (t < -lim) return 0;
         u = (t * 64'sd774541002) >>> 29;
         k = u >>> 20;
         f = u & ((64'd1 << 20) - 1);
         idx = f >> 12;
         rem = f & 64'd4095;
         if (idx > 255) idx = 255;
         lo = exp_tab[idx];
         hi = exp_tab[idx+1];
         m = (hi > lo) ? lo + (((hi - lo) * rem) >> 12) : lo;
         sh = k - 10;
         if (sh >= 0) begin
            if (sh >= 32) return 64'sh7FFFFFFF;
            m <<= sh;
         end else begin
            if (-sh >= 63) return 0;
            m >>= -sh;
         end
         return (m > 64'h7FFFFFFF) ? 64'sh7FFFFFFF : longint'(m);
      endfunction

      function void morse(longint r, longint de, longint re, longint beta,
                          logic [1:0] variant, output longint pot, output longint dv);
         longint e, e2, db;
         e = fexp((beta * (re - r)) >>> 20);
         e2 = clamp32(longint'((longint'(unsigned'(e)) * e) >> 20));
         db = fmul(de, beta);
         if (variant == VAR_MORSE) begin
            pot = fmul(de, clamp32(e2 - 2 * e));
            dv = clamp32(2 * fmul(db, clamp32(e - e2)));
         end else begin
            pot = fmul(de, e2);
            dv = clamp32(-2 * fmul(db, e2));
         end
      endfunction

      function void set_reg(logic idx, logic [30:0] data);
         if (idx == CSR_CUTOFF) rcut = 64'(data);
         else mode = data[1:0];
      endfunction

      // Works out the result word of one accepted pair.
      function void note_pair(pair_word_type w);
         longint r, pot, dv, potc, dvc, pairv, swe, dudr, num, fo;
         longint d[3];
         force_word_type o;
         r = w.r;
         d[0] = w.sx;
         d[1] = w.sy;
         d[2] = w.sz;
         pot = 0; dv = 0; potc = 0; dvc = 0;
         if (w.variant <= VAR_REPULSIVE) begin
            morse(r, w.de, w.re, w.beta, w.variant, pot, dv);
            if (mode[SHIFT_POT_BIT]) begin
               morse(rcut, w.de, w.re, w.beta, w.variant, potc, dvc);
               dvc = 0;
            end else if (mode[SHIFT_FORCE_BIT]) begin
               morse(rcut, w.de, w.re, w.beta, w.variant, potc, dvc);
               potc = clamp32(potc + fmul(dvc, r - rcut));
            end
         end
         pairv = clamp32((longint'(w.vdw) * clamp32(pot - potc)) >>> 20);
         swe = clamp32((longint'(w.sw) * pairv) >>> 20);
         dudr = clamp32((((longint'(w.sw) * longint'(w.vdw)) >>> 20)
                         * clamp32(dv - dvc)) >>> 20);
         o.pair = 32'(pairv);
         o.swe = 32'(swe);
         o.sele = w.sel ? 32'(swe) : 32'sd0;
         for (int i = 0; i < 3; i++) begin
            num = d[i] * dudr;
            if (r == 0) fo = (num > 0) ? 64'sh7FFFFFFF : ((num < 0) ? -64'sh80000000 : 0);
            else fo = clamp32(num / r);
            if (i == 0) o.fx = 32'(fo);
            else if (i == 1) o.fy = 32'(fo);
            else o.fz = 32'(fo);
         end
         expected.push_back(o);
      endfunction

      // Compares one result word with the oldest expectation.
      function void check_word(force_word_type got);
         force_word_type want;
         if (expected.size() == 0) begin
            fails++;
            if (fails <= 10) $display("unexpected result word, pair_energy %0d", got.pair);
            return;
         end
         want = expected.pop_front();
         if (got != want) begin
            fails++;
            if (fails <= 10)
               $display("mismatch: expected %0d %0d %0d %0d %0d %0d, got %0d %0d %0d %0d %0d %0d",
                        want.pair, want.swe, want.sele, want.fx, want.fy, want.fz,
                        got.pair, got.swe, got.sele, got.fx, got.fy, got.fz);
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [30:0]        req_distance = '0;
   logic signed [31:0] req_sep_x = '0, req_sep_y = '0, req_sep_z = '0;
   logic [20:0]        req_vdw_scale = '0, req_switch_value = '0;
   logic               req_is_selected = 1'b0;
   logic [30:0]        req_well_depth = '0, req_eq_distance = '0, req_beta = '0;
   logic [1:0]         req_variant = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [31:0] rsp_pair_energy, rsp_switched_energy, rsp_selected_energy;
   logic signed [31:0] rsp_force_x, rsp_force_y, rsp_force_z;
   logic               csr_write_en = 1'b0;
   logic               csr_index = 1'b0;
   logic [30:0]        csr_wdata = '0;
   logic               steady = 1'b0;

   force_ledger ledger = new();

   morse_pair_force DUT (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Result side: check accepted words, then pick the next ready value.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         ledger.check_word('{rsp_pair_energy, rsp_switched_energy, rsp_selected_energy,
                             rsp_force_x, rsp_force_y, rsp_force_z});
      rsp_ready <= steady || ($urandom_range(99) >= 31);
   end

   // Presents one word and holds it until it is accepted.
   task automatic send_pair(pair_word_type w);
      while (!steady && $urandom_range(99) < 31) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_distance <= w.r;
      req_sep_x <= w.sx;
      req_sep_y <= w.sy;
      req_sep_z <= w.sz;
      req_vdw_scale <= w.vdw;
      req_switch_value <= w.sw;
      req_is_selected <= w.sel;
      req_well_depth <= w.de;
      req_eq_distance <= w.re;
      req_beta <= w.beta;
      req_variant <= w.variant;
      do @(posedge clock); while (!req_ready);
      ledger.note_pair(w);
   endtask

   task automatic write_reg(logic idx, logic [30:0] data);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      ledger.set_reg(idx, data);
   endtask

   // Sets both registers once the pipeline is empty.
   task automatic configure(logic [30:0] cutoff, logic [1:0] mode);
      req_valid <= 1'b0;
      while (ledger.expected.size() != 0) @(posedge clock);
      write_reg(CSR_CUTOFF, cutoff);
      write_reg(CSR_SHIFT_MODE, {29'd0, mode});
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   function automatic pair_word_type mk(longint r, longint x, longint y, longint z,
                                        longint vdw, longint sw, bit sel, longint de,
                                        longint re, longint beta, logic [1:0] variant);
      pair_word_type w;
      w.r = 31'(r); w.sx = 32'(x); w.sy = 32'(y); w.sz = 32'(z);
      w.vdw = 21'(vdw); w.sw = 21'(sw); w.sel = sel;
      w.de = 31'(de); w.re = 31'(re); w.beta = 31'(beta); w.variant = variant;
      return w;
   endfunction

   // Mostly physical pairs, with some words of raw random bits.
   function automatic pair_word_type random_pair();
      pair_word_type w;
      longint r;
      if ($urandom_range(99) < 20) begin
         w = mk($urandom(), $signed($urandom()), $signed($urandom()), $signed($urandom()),
                $urandom_range(0, 21'h1FFFFF), $urandom_range(0, 21'h1FFFFF), 1'($urandom()),
                $urandom(), $urandom(), $urandom(), 2'($urandom_range(0, 3)));
         return w;
      end
      r = $urandom_range(0, 8 << 20);
      w = mk(r, longint'($urandom_range(0, 2 * r)) - r, longint'($urandom_range(0, 2 * r)) - r,
             longint'($urandom_range(0, 2 * r)) - r, $urandom_range(0, ONE),
             $urandom_range(0, ONE), 1'($urandom()), $urandom_range(0, 16 << 20),
             $urandom_range(ONE / 2, 4 << 20), $urandom_range(ONE / 4, 4 << 20),
             2'(($urandom_range(99) < 8) ? $urandom_range(2, 3) : $urandom_range(0, 1)));
      return w;
   endfunction

   task automatic random_phase(int count);
      for (int i = 0; i < count; i++) send_pair(random_pair());
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words: field extremes, all variants, zero distance.
      configure(31'(3 << 20), SHIFT_NONE);
      send_pair(mk(ONE, ONE, 0, 0, ONE, ONE, 1, ONE, ONE, ONE, VAR_MORSE));
      send_pair(mk(2 * ONE, -ONE, ONE, -ONE, ONE, ONE, 1, 4 * ONE, ONE, 2 * ONE, VAR_REPULSIVE));
      send_pair(mk(ONE, ONE, ONE, ONE, ONE, ONE, 1, ONE, ONE, ONE, VAR_UNKNOWN));
      send_pair(mk(ONE, ONE, ONE, ONE, ONE, ONE, 1, ONE, ONE, ONE, VAR_SPARE));
      send_pair(mk(0, ONE, -ONE, 0, ONE, ONE, 1, ONE, 2 * ONE, ONE, VAR_MORSE));
      send_pair(mk(0, ONE, -ONE, 0, ONE, ONE, 0, ONE, ONE / 2, ONE, VAR_MORSE));
      send_pair(mk(0, -ONE, ONE, 0, ONE, ONE, 1, ONE, ONE, ONE, VAR_REPULSIVE));
      send_pair(mk(31'h7FFFFFFF, 32'sh7FFFFFFF, -32'sh80000000, -1, 21'h1FFFFF, 21'h1FFFFF,
                   1, 31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF, VAR_MORSE));
      send_pair(mk(0, -32'sh80000000, 32'sh7FFFFFFF, 0, 21'h1FFFFF, 21'h1FFFFF, 1,
                   31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF, VAR_REPULSIVE));
      send_pair(mk(ONE, ONE, ONE, ONE, 0, 0, 0, 0, 0, 0, VAR_MORSE));
      send_pair(mk(31'h7FFFFFFF, 1, 1, 1, ONE, ONE, 1, ONE, 0, 31'h7FFFFFFF, VAR_MORSE));
      send_pair(mk(0, 1, 1, 1, ONE, ONE, 1, ONE, 31'h7FFFFFFF, 31'h7FFFFFFF, VAR_MORSE));
      send_pair(mk(3 * ONE, ONE, ONE, ONE, ONE, ONE / 2, 1, ONE, ONE, 0, VAR_MORSE));
      configure(31'(2 * ONE), SHIFT_BOTH);
      send_pair(mk(ONE, ONE, 0, ONE, ONE, ONE, 1, 2 * ONE, ONE, ONE, VAR_MORSE));
      send_pair(mk(0, ONE, ONE, -ONE, ONE, ONE, 1, 2 * ONE, ONE, ONE, VAR_REPULSIVE));

      // Random phases over several register settings.
      configure(31'd0, SHIFT_NONE);
      random_phase(120);
      configure(31'($urandom_range(ONE, 6 << 20)), SHIFT_POT);
      random_phase(120);
      steady <= 1'b1;
      configure(31'($urandom_range(ONE, 6 << 20)), SHIFT_FORCE);
      random_phase(120);
      steady <= 1'b0;
      configure(31'($urandom_range(ONE, 6 << 20)), SHIFT_BOTH);
      random_phase(120);
      configure(31'h7FFFFFFF, SHIFT_FORCE);
      random_phase(130);
      configure(31'($urandom()), SHIFT_POT);
      random_phase(130);

      req_valid <= 1'b0;
      while (ledger.expected.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (ledger.fails == 0) $display("[morse_pair_force] OK");
      else $display("[morse_pair_force] ERROR");
      $finish;
   end

   // Overall time limit.
   initial begin
      #4000000;
      $display("[morse_pair_force] ERROR");
      $finish;
   end

endmodule
